// ===== src/multilevel_feedback_queue_scheduler_assert.svh =====
// Assertion macros for the multilevel feedback queue scheduler
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MLFQ_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLFQ_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mlfq_pkg.sv =====
// Shared constants, types and command codes of the MLFQ scheduler
`default_nettype none

package mlfq_pkg;

  localparam int NUM_LEVELS  = 4;
  localparam int NUM_QREGS   = 4;
  localparam int TASK_W      = 6;
  localparam int MAX_TASKS   = 1 << TASK_W;
  localparam int LVL_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int SLOT_W      = $clog2(MAX_TASKS);
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);
  localparam int STORE_AW    = LVL_W + SLOT_W;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int QNT_W       = 16;
  localparam int CMD_W       = 3;
  localparam int CFG_IDX_W   = $clog2(NUM_QREGS);

  localparam logic [QNT_W-1:0] QNT_RESET = QNT_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_UNBLOCK = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_BLOCK   = 3'd3,
    CMD_EXIT    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [LVL_W-1:0]  lvl;
    logic [TASK_W-1:0] val;
  } push_req_t;

  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] lvl;
    logic             bypass;
  } pop_res_t;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [TASK_W-1:0] addr;
    logic [LVL_W-1:0]  data;
  } tab_wr_t;

endpackage

`default_nettype wire

// ===== src/mlfq_ifs.sv =====
// Valid/ready channel interfaces for events in and dispatch results out
`default_nettype none

interface mlfq_in_if;
  import mlfq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TASK_W-1:0] task_id;
  logic [TASK_W-1:0] running_task;
  logic              running_is_idle;

  modport source (output valid, cmd, task_id, running_task, running_is_idle,
                  input ready);
  modport sink   (input valid, cmd, task_id, running_task, running_is_idle,
                  output ready);
endinterface

interface mlfq_out_if;
  import mlfq_pkg::*;
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] next_task;
  logic              next_idle;

  modport source (output valid, next_task, next_idle, input ready);
  modport sink   (input valid, next_task, next_idle, output ready);
endinterface

`default_nettype wire

// ===== src/multilevel_feedback_queue_scheduler.sv =====
// Top level of the multilevel feedback queue scheduler
//
// Usage:
//  - in_ch carries one scheduler event per transaction: cmd (load, unblock,
//    tick, block, exit), task_id, running_task and running_is_idle.
//  - out_ch returns the task to run next (next_task, next_idle) for tick,
//    block and exit events; load, unblock and unknown codes return nothing.
//  - cfg_we/cfg_index/cfg_wdata write the per-level quanta; write only while
//    the block holds no outstanding transaction.
// Timing:
//  - one event accepted per cycle while out_ch does not hold a result back; the
//    result is presented from the result register, which follows the input
//    register, and its task comes from the level store's registered read port.
//  - the single write port and single read port of the level store take one
//    push and one pop per event, which sets the one-event-per-cycle figure.
// Reset: synchronous, active low; all levels empty, every return level 0,
//  quanta 1, current level 0. No clearing pass is needed.
// Back-pressure: a result waiting on out_ch holds the next result-producing
//  event in the input register; events without a result still drain.
`default_nettype none

module multilevel_feedback_queue_scheduler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mlfq_in_if.sink                             in_ch,
  mlfq_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mlfq_pkg::QNT_W-1:0]     cfg_wdata
);
  import mlfq_pkg::*;

  // configuration
  logic [QNT_W-1:0] quanta_r [NUM_QREGS];

  // input register
  logic              s1_vld_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [TASK_W-1:0] s1_task_r;
  logic [TASK_W-1:0] s1_run_r;
  logic              s1_idle_r;

  // scheduler state
  logic [LVL_W-1:0]  cur_level_r;
  logic [QNT_W-1:0]  qleft_r;

  // result register
  logic              s2_vld_r;
  logic              s2_ram_r;
  logic              s2_idle_r;
  logic [TASK_W-1:0] s2_task_r;

  // event decode
  push_req_t         push_q;
  pop_res_t          pop_q;
  tab_wr_t           tab_wr;
  logic              disp;
  logic              has_res;
  logic              tick_dec;
  logic              s1_go;
  logic              in_acc;
  logic [LVL_W-1:0]  ret_lvl;
  logic [TASK_W-1:0] fifo_rd;
  logic [QNT_W-1:0]  q_sel;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_go        = s1_vld_r && (!has_res || !s2_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || s1_go;

  always_comb begin
    push_q   = '0;
    tab_wr   = '0;
    disp     = 1'b0;
    has_res  = 1'b0;
    tick_dec = 1'b0;
    case (s1_cmd_r)
      CMD_LOAD: begin
        push_q.en   = 1'b1;
        push_q.val  = s1_task_r;
        tab_wr.clr  = s1_go;
        tab_wr.addr = s1_task_r;
      end
      CMD_UNBLOCK: begin
        push_q.en  = 1'b1;
        push_q.lvl = ret_lvl;
        push_q.val = s1_task_r;
      end
      CMD_TICK: begin
        has_res = 1'b1;
        if (s1_idle_r) begin
          disp = 1'b1;
        end else if (qleft_r <= QNT_W'(1)) begin
          // quantum used up: demote, bottom level keeps it
          push_q.en  = 1'b1;
          push_q.val = s1_run_r;
          push_q.lvl = (cur_level_r != LVL_W'(NUM_LEVELS - 1)) ?
                       cur_level_r + LVL_W'(1) : cur_level_r;
          disp = 1'b1;
        end else begin
          tick_dec = 1'b1;
        end
      end
      CMD_BLOCK: begin
        has_res     = 1'b1;
        disp        = 1'b1;
        tab_wr.we   = s1_go && !s1_idle_r;
        tab_wr.addr = s1_run_r;
        tab_wr.data = (cur_level_r == '0) ? '0 : cur_level_r - LVL_W'(1);
      end
      CMD_EXIT: begin
        has_res = 1'b1;
        disp    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mlfq_rtab u_rtab (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (in_ch.task_id),
    .cur_task (s1_task_r),
    .wr       (tab_wr),
    .level    (ret_lvl)
  );

  mlfq_fifo_bank u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (s1_go),
    .push    (push_q),
    .pop_req (disp),
    .pop     (pop_q),
    .rd_data (fifo_rd)
  );

  // levels beyond the last quantum register share it
  always_comb begin
    q_sel = quanta_r[NUM_QREGS - 1];
    for (int j = 0; j < NUM_QREGS - 1; j++) begin
      if (pop_q.lvl == LVL_W'(j)) begin
        q_sel = quanta_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_QREGS; j++) begin
        quanta_r[j] <= QNT_RESET;
      end
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      cur_level_r <= '0;
      qleft_r     <= QNT_RESET;
    end else begin
      if (cfg_we) begin
        quanta_r[cfg_index] <= cfg_wdata;
      end

      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end

      // empty dispatch leaves level and quantum untouched
      if (s1_go && disp && pop_q.found) begin
        cur_level_r <= pop_q.lvl;
        qleft_r     <= q_sel;
      end else if (s1_go && tick_dec) begin
        qleft_r <= qleft_r - QNT_W'(1);
      end

      if (s1_go && has_res) begin
        s2_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        s2_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_task_r <= in_ch.task_id;
      s1_run_r  <= in_ch.running_task;
      s1_idle_r <= in_ch.running_is_idle;
    end
    if (s1_go && has_res) begin
      s2_ram_r  <= disp && pop_q.found && !pop_q.bypass;
      s2_idle_r <= disp && !pop_q.found;
      if (!disp) begin
        s2_task_r <= s1_run_r;
      end else if (pop_q.bypass) begin
        s2_task_r <= push_q.val;
      end else begin
        s2_task_r <= '0;
      end
    end
  end

  assign out_ch.valid     = s2_vld_r;
  assign out_ch.next_idle = s2_idle_r;
  assign out_ch.next_task = s2_ram_r ? fifo_rd : s2_task_r;

  `include "multilevel_feedback_queue_scheduler_assert.svh"

  `MLFQ_ASSERT_NOW(a_no_overwrite, clk, rst_n, s1_go && has_res, !s2_vld_r || out_ch.ready, "result register overwritten while stalled")
  `MLFQ_ASSERT_NOW(a_bypass_level, clk, rst_n, s1_go && pop_q.bypass, push_q.en && push_q.lvl == pop_q.lvl, "store bypass without push at the popped level")
  `MLFQ_ASSERT_NXT(a_qleft_dec, clk, rst_n, s1_go && tick_dec, qleft_r == $past(qleft_r) - QNT_W'(1), "quantum not decremented on tick")
  `MLFQ_ASSERT_NXT(a_level_upd, clk, rst_n, s1_go && disp && pop_q.found, cur_level_r == $past(pop_q.lvl), "current level not taken from dispatch")

endmodule

`default_nettype wire

// ===== src/mlfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/mlfq_rtab.sv =====
// Per-task return level table: RAM, per-entry valid bits, write forwarding
`default_nettype none

module mlfq_rtab (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire logic [mlfq_pkg::TASK_W-1:0]   rd_addr,
  input  wire logic [mlfq_pkg::TASK_W-1:0]   cur_task,
  input  wire mlfq_pkg::tab_wr_t             wr,
  output logic      [mlfq_pkg::LVL_W-1:0]    level
);
  import mlfq_pkg::*;

  logic [MAX_TASKS-1:0] vld_r;
  logic                 fwd_vld_r;
  logic [LVL_W-1:0]     fwd_data_r;
  logic [LVL_W-1:0]     rdata;

  mlfq_ram #(.WIDTH(LVL_W), .DEPTH(MAX_TASKS)) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // a cleared entry reads as level 0 (task loaded or never blocked)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end else if (wr.clr) begin
        vld_r[wr.addr] <= 1'b0;
      end
      // RAM reads old data when written at the same edge
      if (rd_en) begin
        fwd_vld_r <= wr.we && (wr.addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr.data;
    end
  end

  always_comb begin
    if (!vld_r[cur_task]) begin
      level = '0;
    end else if (fwd_vld_r) begin
      level = fwd_data_r;
    end else begin
      level = rdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/mlfq_fifo_bank.sv =====
// Per-level FIFO pointers, priority pick of the dispatch level, shared store
`default_nettype none

module mlfq_fifo_bank (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire mlfq_pkg::push_req_t         push,
  input  wire logic                        pop_req,
  output mlfq_pkg::pop_res_t               pop,
  output logic      [mlfq_pkg::TASK_W-1:0] rd_data
);
  import mlfq_pkg::*;

  logic [SLOT_W-1:0]     head_r [NUM_LEVELS];
  logic [CNT_W-1:0]      cnt_r  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] push_do;
  logic [NUM_LEVELS-1:0] pop_do;
  logic [NUM_LEVELS-1:0] nonempty;
  logic [NUM_LEVELS-1:0] empty_now;
  logic [SLOT_W-1:0]     wslot;
  logic [SLOT_W-1:0]     rslot;
  logic                  push_ok;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      empty_now[i] = (cnt_r[i] == '0);
      push_do[i]   = push.en && (push.lvl == LVL_W'(i))
                     && (cnt_r[i] != CNT_W'(MAX_TASKS));
      nonempty[i]  = !empty_now[i] || push_do[i];
    end
    push_ok = |push_do;

    // level 0 is the highest priority
    pop.found = 1'b0;
    pop.lvl   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pop.found = 1'b1;
        pop.lvl   = LVL_W'(i);
      end
    end

    for (int i = 0; i < NUM_LEVELS; i++) begin
      pop_do[i] = pop_req && pop.found && (pop.lvl == LVL_W'(i));
    end
    // popping an entry pushed in this very event onto an empty level
    pop.bypass = |(pop_do & push_do & empty_now);

    wslot = '0;
    rslot = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (push.lvl == LVL_W'(i)) begin
        wslot = head_r[i] + cnt_r[i][SLOT_W-1:0];
      end
      if (pop.lvl == LVL_W'(i)) begin
        rslot = head_r[i];
      end
    end
  end

  mlfq_ram #(.WIDTH(TASK_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (go && push_ok),
    .waddr ({push.lvl, wslot}),
    .wdata (push.val),
    .re    (go && (|pop_do)),
    .raddr ({pop.lvl, rslot}),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (go) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (pop_do[i]) begin
          head_r[i] <= head_r[i] + SLOT_W'(1);
        end
        cnt_r[i] <= cnt_r[i] + CNT_W'(push_do[i]) - CNT_W'(pop_do[i]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_multilevel_feedback_queue_scheduler.sv =====
`timescale 1ns / 100ps
// Testbench for the MLFQ scheduler: directed event sequences, then random scheduling traffic
module tb_multilevel_feedback_queue_scheduler;
  import mlfq_pkg::*;

  // generous ceiling on the simulated run length
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // block has an input and a result register; let it settle before touching the quanta
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 200;

  // codes past exit are unused and must be swallowed silently
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_W'(CMD_EXIT) + CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;
  localparam logic [QNT_W-1:0] QNT_MAX          = '1;
  localparam logic [QNT_W-1:0] QNT_ZERO         = '0;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [TASK_W-1:0] task_id;
    logic [TASK_W-1:0] running;
    logic              running_idle;
  } sched_event_t;

  typedef struct {
    logic [TASK_W-1:0] next_task;
    logic              next_idle;
  } dispatch_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [QNT_W-1:0]     cfg_wdata;

  mlfq_in_if  in_ch();
  mlfq_out_if out_ch();

  multilevel_feedback_queue_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler shadow state: one FIFO per level, return level per task id,
  // the level the running task came from and its remaining ticks.
  // ---------------------------------------------------------------------------
  logic [TASK_W-1:0] lvl_store [NUM_LEVELS][MAX_TASKS];
  logic [SLOT_W-1:0] lvl_head  [NUM_LEVELS];
  int unsigned       lvl_count [NUM_LEVELS];
  logic [LVL_W-1:0]  return_lvl [MAX_TASKS];
  int unsigned       run_lvl;
  logic [QNT_W-1:0]  quantum_left;
  logic [QNT_W-1:0]  quantum [NUM_QREGS];

  // dispatch decisions still owed by the block, oldest first
  dispatch_t pending_dispatch [$];

  // what the processor runs according to the decisions issued so far;
  // lets the random traffic report a plausible running task
  logic [TASK_W-1:0] cpu_task;
  logic              cpu_idle;

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  bit          tx_steady = 1'b0;

  function automatic void sched_reset();
    for (int l = 0; l < NUM_LEVELS; l++) begin
      lvl_head[l]  = '0;
      lvl_count[l] = 0;
    end
    foreach (return_lvl[t]) return_lvl[t] = '0;
    foreach (quantum[i]) quantum[i] = QNT_RESET;
    run_lvl      = 0;
    quantum_left = QNT_RESET;
    cpu_task     = '0;
    cpu_idle     = 1'b1;
  endfunction

  // levels past the last register share the last quantum
  function automatic logic [QNT_W-1:0] level_quantum(int unsigned l);
    return quantum[(l < NUM_QREGS) ? l : NUM_QREGS - 1];
  endfunction

  function automatic void level_push(int unsigned l, logic [TASK_W-1:0] t);
    logic [SLOT_W-1:0] slot;
    if (lvl_count[l] >= MAX_TASKS) return;  // full level: push is lost
    slot = lvl_head[l] + SLOT_W'(lvl_count[l]);
    lvl_store[l][slot] = t;
    lvl_count[l]++;
  endfunction

  // head of the highest non-empty level; idle when all are empty, in which
  // case the current level and remaining quantum are left alone
  function automatic dispatch_t pick_next();
    dispatch_t d;
    d.next_task = '0;
    d.next_idle = 1'b1;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (lvl_count[l] != 0) begin
        d.next_task = lvl_store[l][lvl_head[l]];
        d.next_idle = 1'b0;
        lvl_head[l]++;
        lvl_count[l]--;
        run_lvl      = l;
        quantum_left = level_quantum(l);
        return d;
      end
    end
    return d;
  endfunction

  // applies one event to the shadow state; returns 1 when it yields a decision
  function automatic bit sched_predict(sched_event_t e, output dispatch_t d);
    int unsigned drop_lvl;
    d.next_task = '0;
    d.next_idle = 1'b1;
    case (e.cmd)
      CMD_LOAD: begin
        level_push(0, e.task_id);
        return_lvl[e.task_id] = '0;
        return 1'b0;
      end
      CMD_UNBLOCK: begin
        level_push(return_lvl[e.task_id], e.task_id);
        return 1'b0;
      end
      CMD_TICK: begin
        if (e.running_idle) begin
          d = pick_next();
        end else if (quantum_left <= 1) begin
          // quantum used up (a zero quantum counts as one): drop a level,
          // the bottom level keeps its tasks
          drop_lvl = (run_lvl + 1 < NUM_LEVELS) ? run_lvl + 1 : run_lvl;
          level_push(drop_lvl, e.running);
          d = pick_next();
        end else begin
          quantum_left--;
          d.next_task = e.running;
          d.next_idle = 1'b0;
        end
        return 1'b1;
      end
      CMD_BLOCK: begin
        // idle blocking records nothing; level 0 floors at 0
        if (!e.running_idle)
          return_lvl[e.running] = (run_lvl == 0) ? '0 : LVL_W'(run_lvl - 1);
        d = pick_next();
        return 1'b1;
      end
      CMD_EXIT: begin
        d = pick_next();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers shared by the tests
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic sched_event_t mk_event(logic [CMD_W-1:0] c, logic [TASK_W-1:0] t,
                                            logic [TASK_W-1:0] r, logic i);
    sched_event_t e;
    e.cmd          = c;
    e.task_id      = t;
    e.running      = r;
    e.running_idle = i;
    return e;
  endfunction

  // Sends one event transaction. valid stays high between back-to-back
  // transactions and is only dropped for a gap, so it never sees two
  // updates in one time step.
  task automatic send_event(sched_event_t e);
    int unsigned gap;
    dispatch_t   d;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= e.cmd;
    in_ch.task_id         <= e.task_id;
    in_ch.running_task    <= e.running;
    in_ch.running_is_idle <= e.running_idle;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (sched_predict(e, d)) begin
      pending_dispatch = {pending_dispatch, d};
      cpu_task = d.next_task;
      cpu_idle = d.next_idle;
    end
  endtask

  // sender holds off until every decision is back, then lets the pipe empty
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_dispatch.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block quiet
  task automatic set_quanta(input logic [QNT_W-1:0] q0, q1, q2, q3);
    logic [QNT_W-1:0] vals [NUM_QREGS];
    vals = '{q0, q1, q2, q3};
    for (int i = 0; i < NUM_QREGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      quantum[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  // Random event, weighted per command; a few percent unused codes.
  // Nine in ten report the task the last decision put on the processor.
  function automatic sched_event_t make_event(int unsigned w_load, int unsigned w_unblock,
                                              int unsigned w_tick, int unsigned w_block,
                                              int unsigned w_exit);
    sched_event_t e;
    int unsigned  pick;
    pick = $urandom_range(w_load + w_unblock + w_tick + w_block + w_exit + 2);
    if (pick < w_load)
      e.cmd = CMD_LOAD;
    else if (pick < w_load + w_unblock)
      e.cmd = CMD_UNBLOCK;
    else if (pick < w_load + w_unblock + w_tick)
      e.cmd = CMD_TICK;
    else if (pick < w_load + w_unblock + w_tick + w_block)
      e.cmd = CMD_BLOCK;
    else if (pick < w_load + w_unblock + w_tick + w_block + w_exit)
      e.cmd = CMD_EXIT;
    else
      e.cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    // a small pool of ids makes repeats and re-entries likely
    e.task_id = ($urandom_range(2) == 0) ? TASK_W'($urandom_range(MAX_TASKS - 1))
                                         : TASK_W'($urandom_range(7));
    if ($urandom_range(9) != 0) begin
      e.running      = cpu_idle ? TASK_W'($urandom_range(MAX_TASKS - 1)) : cpu_task;
      e.running_idle = cpu_idle;
    end else begin
      e.running      = TASK_W'($urandom_range(MAX_TASKS - 1));
      e.running_idle = 1'($urandom_range(1));
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // empty dispatch, demotion, bottom level, block floor, idle block, unused codes
  task automatic test_directed_basics();
    send_event(mk_event(CMD_EXIT,    0,  0,  1'b1));  // nothing queued: idle
    send_event(mk_event(CMD_TICK,    0,  63, 1'b1));  // idle tick, still empty
    send_event(mk_event(CMD_LOAD,    63, 0,  1'b1));
    send_event(mk_event(CMD_LOAD,    0,  0,  1'b1));
    send_event(mk_event(CMD_EXIT,    0,  0,  1'b1));  // 63 from top level
    send_event(mk_event(CMD_TICK,    0,  63, 1'b0));  // 63 expires to level one
    send_event(mk_event(CMD_TICK,    0,  0,  1'b0));  // 0 follows it down
    send_event(mk_event(CMD_BLOCK,   0,  63, 1'b0));  // blocked at level one
    send_event(mk_event(CMD_UNBLOCK, 63, 0,  1'b0));  // comes back at the top
    send_event(mk_event(CMD_UNUSED_FIRST,     63, 63, 1'b1));
    send_event(mk_event(CMD_UNUSED_FIRST + CMD_W'(1), 0,  63, 1'b0));
    send_event(mk_event(CMD_UNUSED_LAST,      63, 0,  1'b1));
    send_event(mk_event(CMD_TICK,    0,  0,  1'b0));  // 0 drops to level two
    send_event(mk_event(CMD_BLOCK,   0,  63, 1'b0));  // block at top: floored
    send_event(mk_event(CMD_TICK,    0,  0,  1'b0));  // into the bottom level
    send_event(mk_event(CMD_TICK,    0,  0,  1'b0));  // bottom level keeps it
    send_event(mk_event(CMD_BLOCK,   0,  0,  1'b0));  // returns one level up
    send_event(mk_event(CMD_BLOCK,   0,  5,  1'b1));  // idle block: no record
    send_event(mk_event(CMD_UNBLOCK, 0,  0,  1'b1));
    send_event(mk_event(CMD_UNBLOCK, 63, 0,  1'b1));
    send_event(mk_event(CMD_EXIT,    0,  0,  1'b1));
    send_event(mk_event(CMD_EXIT,    0,  63, 1'b0));
    send_event(mk_event(CMD_EXIT,    0,  0,  1'b0));
  endtask

  // countdown, per-level reload and a zero quantum at level two
  task automatic test_quantum_countdown();
    set_quanta(3, 1, QNT_ZERO, 2);
    send_event(mk_event(CMD_LOAD, 21, 0, 1'b1));
    send_event(mk_event(CMD_EXIT, 0,  0, 1'b1));
    repeat (7) send_event(mk_event(CMD_TICK, 0, 21, 1'b0));
    send_event(mk_event(CMD_BLOCK,   0,  21, 1'b0));
    send_event(mk_event(CMD_UNBLOCK, 21, 0,  1'b1));
    send_event(mk_event(CMD_EXIT,    0,  0,  1'b1));
    send_event(mk_event(CMD_EXIT,    0,  21, 1'b0));
  endtask

  // overfill the top level so the surplus loads are lost, then empty it
  task automatic test_full_level();
    repeat (MAX_TASKS + 6)
      send_event(mk_event(CMD_LOAD, TASK_W'($urandom_range(MAX_TASKS - 1)),
                          TASK_W'($urandom_range(MAX_TASKS - 1)), 1'($urandom_range(1))));
    repeat (MAX_TASKS + 6)
      send_event(mk_event(CMD_EXIT, TASK_W'($urandom_range(MAX_TASKS - 1)),
                          TASK_W'($urandom_range(MAX_TASKS - 1)), 1'($urandom_range(1))));
  endtask

  // each chunk picks at random between filling the levels, draining them and a mix
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned profile;
    sent = 0;
    while (sent < n_items) begin
      profile   = $urandom_range(2);
      tx_steady = ($urandom_range(4) == 0);
      for (int k = 0; k < 50 && sent < n_items; k++) begin
        case (profile)
          0:       send_event(make_event(30, 15, 35, 8, 7));
          1:       send_event(make_event(8, 10, 40, 20, 22));
          default: send_event(make_event(15, 12, 45, 14, 14));
        endcase
        sent++;
      end
    end
    tx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, each decision checked against the
  // oldest one owed
  // ---------------------------------------------------------------------------
  initial begin : result_check
    int unsigned stall;
    bit          rx_steady;
    dispatch_t   want;
    stall     = 0;
    rx_steady = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_dispatch.size() == 0) begin
          flag_error($sformatf("unexpected transaction: next_task %0d next_idle %0b",
                               out_ch.next_task, out_ch.next_idle));
        end else begin
          want = pending_dispatch.pop_front();
          if (out_ch.next_task !== want.next_task)
            flag_error($sformatf("next_task %0d, expected %0d",
                                 out_ch.next_task, want.next_task));
          if (out_ch.next_idle !== want.next_idle)
            flag_error($sformatf("next_idle %0b, expected %0b",
                                 out_ch.next_idle, want.next_idle));
        end
      end
      // now and then switch between stalling and taking every result
      if ($urandom_range(255) == 0) rx_steady = ~rx_steady;
      if (stall != 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_steady) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= CMD_LOAD;
    in_ch.task_id         <= '0;
    in_ch.running_task    <= '0;
    in_ch.running_is_idle <= 1'b1;
    sched_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    wait_quiet();
    test_quantum_countdown();
    wait_quiet();
    test_full_level();
    wait_quiet();

    set_quanta(1, 1, 1, 1);
    test_random_traffic(420);
    wait_quiet();
    set_quanta(QNT_W'($urandom_range(1, 4)), QNT_W'($urandom_range(1, 4)),
               QNT_W'($urandom_range(1, 4)), QNT_W'($urandom_range(1, 4)));
    test_random_traffic(420);
    wait_quiet();
    // dispatched tasks never expire: ticks keep the running task, new picks come from block, exit and idle ticks
    set_quanta(QNT_MAX, QNT_MAX, QNT_MAX, QNT_MAX);
    test_random_traffic(250);
    wait_quiet();
    set_quanta(2, QNT_MAX, 1, QNT_ZERO);
    test_random_traffic(380);
    wait_quiet();
    set_quanta(QNT_W'($urandom_range(0, 5)), QNT_W'($urandom_range(0, 5)),
               QNT_W'($urandom_range(0, 5)), QNT_W'($urandom_range(0, 5)));
    test_random_traffic(250);
    wait_quiet();

    if (err_cnt == 0 && pending_dispatch.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
